[sv/cmdd_pkg.sv]
package cmdd_pkg;

  localparam int CNT_W     = 7;
  localparam int HDR_BYTES = 10;
  localparam int IDX_OUT_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [15:0] FRAME_MAGIC = 16'h2934;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_TOP     = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_PORT = CFG_IDX_W'(1);

  typedef logic [2:0] status_t;
  localparam status_t ST_GOOD      = 3'd0;
  localparam status_t ST_OWN       = 3'd1;
  localparam status_t ST_SHORT     = 3'd2;
  localparam status_t ST_BAD_MAGIC = 3'd3;
  localparam status_t ST_BAD_CRC   = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic take_byte;
    logic load_single;
    logic burst_load;
    logic clear_frame;
    logic ptr_clr;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic good_data;
    logic ptr_last;
  } dp_stat_t;

  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                               input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) c = (c << 1) ^ CRC_POLY;
      else c = c << 1;
    end
    return c;
  endfunction

endpackage

[sv/can_mcast_datagram_deframer.sv]
// Datagram deframer for CAN frames carried over UDP multicast.
// Input channel (in_valid / in_stall): one datagram byte per request, with
// in_last_byte on the final byte and the datagram's source address and port.
// Configuration channel (cfg_valid / cfg_ready, always ready): index 0 sets
// the own source address, index 1 the own source port; other indexes ignored.
// Result channel (out_valid / out_stall): one status result for a dropped or
// rejected datagram, or one result per data byte for a good frame (a single
// result with out_byte_valid low when it has no data).
// Throughput: header and data bytes are taken one per cycle in S_RX. A
// status result is registered on the edge that takes the final byte.
// A good frame first passes S_PREP, where the first data-store read is
// made; its data results are then loaded in S_BURST, one byte per cycle
// while the output register is free, from the data store, which has one
// write and one read port. Input is held stalled through S_PREP and the
// burst; the next byte is taken once the last data result is loaded.
// A final byte is stalled while the previous result waits in the output
// register; other bytes keep flowing. out_stall holds the output register.
// Reset clears the frame state, the error counter and the configuration; the
// data store needs no clearing.
module can_mcast_datagram_deframer #(
  parameter int MAX_DATA = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  input  logic                          in_last_byte,
  input  logic [31:0]                   in_source_addr,
  input  logic [15:0]                   in_source_port,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cmdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [31:0]                   out_frame_id,
  output logic [6:0]                    out_payload_len,
  output logic [5:0]                    out_byte_index,
  output logic [7:0]                    out_data_byte,
  output logic                          out_byte_valid,
  output logic                          out_last_result,
  output logic [31:0]                   out_error_count
);

  cmdd_pkg::ctl_cmd_t cmd;
  cmdd_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  cmdd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  cmdd_datapath #(
    .MAX_DATA (MAX_DATA)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_rx_byte      (in_rx_byte),
    .in_source_addr  (in_source_addr),
    .in_source_port  (in_source_port),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_frame_id    (out_frame_id),
    .out_payload_len (out_payload_len),
    .out_byte_index  (out_byte_index),
    .out_data_byte   (out_data_byte),
    .out_byte_valid  (out_byte_valid),
    .out_last_result (out_last_result),
    .out_error_count (out_error_count)
  );

endmodule

[sv/cmdd_datapath.sv]
module cmdd_datapath #(
  parameter int MAX_DATA = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmdd_pkg::ctl_cmd_t            cmd,
  output cmdd_pkg::dp_stat_t            stat,
  input  logic [7:0]                    in_rx_byte,
  input  logic [31:0]                   in_source_addr,
  input  logic [15:0]                   in_source_port,
  input  logic                          cfg_valid,
  input  logic [cmdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [31:0]                   out_frame_id,
  output logic [6:0]                    out_payload_len,
  output logic [5:0]                    out_byte_index,
  output logic [7:0]                    out_data_byte,
  output logic                          out_byte_valid,
  output logic                          out_last_result,
  output logic [31:0]                   out_error_count
);

  localparam int IDX_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam logic [cmdd_pkg::CNT_W-1:0] HDR   = cmdd_pkg::CNT_W'(cmdd_pkg::HDR_BYTES);
  localparam logic [cmdd_pkg::CNT_W-1:0] FULL  =
    cmdd_pkg::CNT_W'(cmdd_pkg::HDR_BYTES + MAX_DATA);

  logic [31:0] own_addr_r;
  logic [15:0] own_port_r;

  logic [cmdd_pkg::CNT_W-1:0] cnt_r, cnt_upd;
  logic [15:0] crc_r, crc_upd;
  logic [15:0] magic_r, magic_upd;
  logic [15:0] hcrc_r, hcrc_upd;
  logic [31:0] id_r, id_upd;
  logic [31:0] err_r, err_nxt;

  logic [7:0] data_store [MAX_DATA];
  logic [7:0] q_r;
  logic [IDX_W-1:0] ptr_r, rd_addr, wr_idx;
  logic wr_en;

  logic [cmdd_pkg::CNT_W-1:0] len_r;
  cmdd_pkg::status_t cls;
  logic [cmdd_pkg::CNT_W-1:0] len_upd;

  logic out_valid_r;
  logic [2:0] status_r;
  logic [31:0] id_out_r, err_out_r;
  logic [6:0] len_out_r;
  logic [5:0] idx_out_r;
  logic [7:0] byte_out_r;
  logic bvalid_r, last_r;

  // frame header / crc update for the byte being taken
  always_comb begin
    cnt_upd   = cnt_r;
    crc_upd   = crc_r;
    magic_upd = magic_r;
    hcrc_upd  = hcrc_r;
    id_upd    = id_r;
    wr_en     = 1'b0;
    wr_idx    = IDX_W'(cnt_r - HDR);
    if (cnt_r < FULL) begin
      cnt_upd = cnt_r + 1'b1;
      case (cnt_r)
        7'd0: magic_upd[7:0]  = in_rx_byte;
        7'd1: magic_upd[15:8] = in_rx_byte;
        7'd2: hcrc_upd[7:0]   = in_rx_byte;
        7'd3: hcrc_upd[15:8]  = in_rx_byte;
        7'd6: id_upd[7:0]     = in_rx_byte;
        7'd7: id_upd[15:8]    = in_rx_byte;
        7'd8: id_upd[23:16]   = in_rx_byte;
        7'd9: id_upd[31:24]   = in_rx_byte;
        default: wr_en = (cnt_r >= HDR);
      endcase
      if (cnt_r >= 7'd4) crc_upd = cmdd_pkg::crc_add_byte(crc_r, in_rx_byte);
    end
  end

  // classification on the final byte
  always_comb begin
    len_upd = cnt_upd - HDR;
    if (in_source_addr == own_addr_r && in_source_port == own_port_r)
      cls = cmdd_pkg::ST_OWN;
    else if (cnt_upd < HDR)
      cls = cmdd_pkg::ST_SHORT;
    else if (magic_upd != cmdd_pkg::FRAME_MAGIC)
      cls = cmdd_pkg::ST_BAD_MAGIC;
    else if (hcrc_upd != crc_upd)
      cls = cmdd_pkg::ST_BAD_CRC;
    else
      cls = cmdd_pkg::ST_GOOD;
  end

  assign len_r = cnt_r - HDR;

  always_comb begin
    err_nxt = err_r;
    if (cmd.load_single && cls != cmdd_pkg::ST_GOOD && cls != cmdd_pkg::ST_OWN)
      err_nxt = err_r + 32'd1;
  end

  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.good_data = (cls == cmdd_pkg::ST_GOOD) && (len_upd != '0);
  assign stat.ptr_last  = (cmdd_pkg::CNT_W'(ptr_r) + 1'b1) == len_r;

  // keep q_r equal to the entry at ptr_r
  assign rd_addr = cmd.burst_load ? ptr_r + 1'b1 : ptr_r;

  always_ff @(posedge clk) begin
    if (cmd.take_byte && wr_en) data_store[wr_idx] <= in_rx_byte;
    q_r <= data_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= '0;
      own_port_r <= '0;
      err_r      <= '0;
      cnt_r      <= '0;
      crc_r      <= cmdd_pkg::CRC_INIT;
      magic_r    <= '0;
      hcrc_r     <= '0;
      id_r       <= '0;
      ptr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == cmdd_pkg::CFG_OWN_ADDR) own_addr_r <= cfg_data;
        if (cfg_index == cmdd_pkg::CFG_OWN_PORT) own_port_r <= cfg_data[15:0];
      end
      err_r <= err_nxt;
      if (cmd.clear_frame) begin
        cnt_r   <= '0;
        crc_r   <= cmdd_pkg::CRC_INIT;
        magic_r <= '0;
        hcrc_r  <= '0;
        id_r    <= '0;
      end else if (cmd.take_byte) begin
        cnt_r   <= cnt_upd;
        crc_r   <= crc_upd;
        magic_r <= magic_upd;
        hcrc_r  <= hcrc_upd;
        id_r    <= id_upd;
      end
      if (cmd.ptr_clr) ptr_r <= '0;
      else if (cmd.burst_load) ptr_r <= ptr_r + 1'b1;
      if (cmd.load_single || cmd.burst_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      status_r   <= cls;
      id_out_r   <= (cls == cmdd_pkg::ST_GOOD) ? id_upd : 32'd0;
      len_out_r  <= '0;
      idx_out_r  <= '0;
      byte_out_r <= '0;
      bvalid_r   <= 1'b0;
      last_r     <= 1'b1;
      err_out_r  <= err_nxt;
    end else if (cmd.burst_load) begin
      status_r   <= cmdd_pkg::ST_GOOD;
      id_out_r   <= id_r;
      len_out_r  <= len_r;
      idx_out_r  <= cmdd_pkg::IDX_OUT_W'(ptr_r);
      byte_out_r <= q_r;
      bvalid_r   <= 1'b1;
      last_r     <= stat.ptr_last;
      err_out_r  <= err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_frame_id    = id_out_r;
  assign out_payload_len = len_out_r;
  assign out_byte_index  = idx_out_r;
  assign out_data_byte   = byte_out_r;
  assign out_byte_valid  = bvalid_r;
  assign out_last_result = last_r;
  assign out_error_count = err_out_r;

endmodule

[sv/cmdd_ctrl.sv]
module cmdd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last_byte,
  output logic               in_stall,
  input  cmdd_pkg::dp_stat_t stat,
  output cmdd_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_RX,
    S_PREP,
    S_BURST
  } state_t;

  state_t state_r, state_nxt;
  logic accept;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    accept    = 1'b0;
    case (state_r)
      S_RX: begin
        // hold the final byte until the output register can take its result
        in_stall = in_last_byte && !stat.out_free;
        accept   = in_valid && !in_stall;
        cmd.take_byte = accept;
        if (accept && in_last_byte) begin
          if (stat.good_data) begin
            cmd.ptr_clr = 1'b1;
            state_nxt   = S_PREP;
          end else begin
            cmd.load_single = 1'b1;
            cmd.clear_frame = 1'b1;
          end
        end
      end
      S_PREP: begin
        // first data read is in flight
        state_nxt = S_BURST;
      end
      S_BURST: begin
        if (stat.out_free) begin
          cmd.burst_load = 1'b1;
          if (stat.ptr_last) begin
            cmd.clear_frame = 1'b1;
            state_nxt       = S_RX;
          end
        end
      end
      default: state_nxt = S_RX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RX;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
